// ===== hdl/rch_pkg.sv =====
// Shared types and constants for the RGB channel histogram.
package rch_pkg;

    localparam int VALUE_W = 8;
    localparam int COUNT_W = 17;
    localparam int PORT_CHANNELS = 3;

    localparam logic [COUNT_W-1:0] FRAME_SIZE = 17'd65536;

    localparam logic MODE_ACCUMULATE = 1'b0;
    localparam logic MODE_READ       = 1'b1;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [COUNT_W-1:0] t_count;

    // Per-channel request towards one bin table.
    typedef struct packed {
        logic clear;   // reset sweep write of zero
        logic valid;   // an item enters this cycle
        logic read;    // read and clear instead of increment
        logic hit;     // the value addresses a bin that exists
    } t_chan_req;

    // One result item as held in the output queue.
    typedef struct packed {
        t_value                   bin_number;
        t_count [PORT_CHANNELS-1:0] counts;
    } t_result;

endpackage

// ===== hdl/rgb_channel_histogram_core.sv =====
// Top level of the RGB channel histogram: per-channel bin tables and result queue.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one item per handshake.
//   i_mode low accumulates one pixel: the bins addressed by i_blue, i_green
//   and i_red each count up by one, saturating at 65536. No result follows.
//   i_mode high reads bin i_bin_index of every channel and clears it; one
//   result item leaves on the output channel (o_out_valid / i_out_ready).
//   Reading all bins in turn leaves the tables empty for the next frame.
// Throughput and pipeline
//   One item per cycle is taken, pixels and reads alike, while o_in_ready
//   is high. A read result is queued from the modify stage. Each table is
//   one RAM with a registered read; the increment and the write back take
//   the following cycle, and a one-entry write-back register forwards the
//   fresh count when consecutive items hit the same bin.
// Reset
//   After reset the tables are swept to zero, one entry per cycle;
//   o_in_ready stays low until the sweep is done.
// Stalls
//   Results wait in a two-entry queue. Input stays open while the queue
//   can absorb the result of every item in flight, so a stalled receiver
//   stops input once queued results plus a read in the modify stage reach two.
module rgb_channel_histogram_core #(
    parameter int BIN_COUNT     = 256,
    parameter int CHANNEL_COUNT = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_mode,
    input  rch_pkg::t_value       i_blue,
    input  rch_pkg::t_value       i_green,
    input  rch_pkg::t_value       i_red,
    input  rch_pkg::t_value       i_bin_index,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output rch_pkg::t_value       o_bin_number,
    output rch_pkg::t_count       o_blue_count,
    output rch_pkg::t_count       o_green_count,
    output rch_pkg::t_count       o_red_count
);

    localparam int ADDR_W = $clog2(BIN_COUNT);

    // Reset sweep state
    logic                r_clearing;
    logic [ADDR_W-1:0]   r_clr_addr;

    // Read item in the modify stage
    logic                r_s1_read;
    rch_pkg::t_value     r_s1_bin;

    logic                in_accept;
    logic                out_pop;
    logic [2:0]          occupancy;
    logic [1:0]          q_level;
    rch_pkg::t_value     chan_value [rch_pkg::PORT_CHANNELS];
    rch_pkg::t_count     chan_count [rch_pkg::PORT_CHANNELS];
    rch_pkg::t_result    push_data;
    rch_pkg::t_result    head;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_pop   = o_out_valid && i_out_ready;

    // Results that will sit in the queue once this cycle's pop and the
    // read in the modify stage are settled; leave room for one more.
    assign occupancy  = 3'(q_level) + 3'(r_s1_read) - 3'(out_pop);
    assign o_in_ready = !r_clearing && (occupancy < 3'd2);

    assign chan_value[0] = i_blue;
    assign chan_value[1] = i_green;
    assign chan_value[2] = i_red;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_s1_read  <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(BIN_COUNT - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            r_s1_read <= in_accept && (i_mode == rch_pkg::MODE_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_bin <= i_bin_index;
    end

    for (genvar ch = 0; ch < rch_pkg::PORT_CHANNELS; ch++) begin : g_chan
        if (ch < CHANNEL_COUNT) begin : g_kept
            rch_pkg::t_value    value;
            rch_pkg::t_chan_req req;

            // A read addresses the named bin; a pixel addresses its own value.
            assign value     = (i_mode == rch_pkg::MODE_READ) ? i_bin_index : chan_value[ch];
            assign req.clear = r_clearing;
            assign req.valid = in_accept;
            assign req.read  = (i_mode == rch_pkg::MODE_READ);
            assign req.hit   = (32'(value) < BIN_COUNT);

            rch_chan #(
                .BIN_COUNT (BIN_COUNT)
            ) u_chan (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_req      (req),
                .i_addr     (ADDR_W'(value)),
                .i_clr_addr (r_clr_addr),
                .o_count    (chan_count[ch])
            );
        end else begin : g_absent
            // Channel not kept: always reads as empty.
            assign chan_count[ch] = '0;
        end
    end

    assign push_data.bin_number = r_s1_bin;
    assign push_data.counts[0]  = chan_count[0];
    assign push_data.counts[1]  = chan_count[1];
    assign push_data.counts[2]  = chan_count[2];

    rch_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_read),
        .i_data  (push_data),
        .i_pop   (out_pop),
        .o_valid (o_out_valid),
        .o_data  (head),
        .o_level (q_level)
    );

    assign o_bin_number  = head.bin_number;
    assign o_blue_count  = head.counts[0];
    assign o_green_count = head.counts[1];
    assign o_red_count   = head.counts[2];

endmodule

// ===== hdl/rch_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rch_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Read returns the old contents when both ports hit the same entry.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/rch_chan.sv =====
// One channel's bin table with read-modify-write and write-back forwarding.
module rch_chan #(
    parameter int BIN_COUNT = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rch_pkg::t_chan_req           i_req,
    input  logic [$clog2(BIN_COUNT)-1:0] i_addr,
    input  logic [$clog2(BIN_COUNT)-1:0] i_clr_addr,
    output rch_pkg::t_count              o_count
);

    localparam int ADDR_W = $clog2(BIN_COUNT);

    rch_pkg::t_chan_req  r_s1;
    logic [ADDR_W-1:0]   r_s1_addr;
    logic                r_wb_valid;
    logic [ADDR_W-1:0]   r_wb_addr;
    rch_pkg::t_count     r_wb_data;

    rch_pkg::t_count     ram_rd_data;
    rch_pkg::t_count     cur;
    rch_pkg::t_count     upd;
    logic                item_wr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    rch_pkg::t_count     wr_data;

    // Take the last write-back when it targets the entry just read.
    assign cur = (r_wb_valid && (r_wb_addr == r_s1_addr)) ? r_wb_data : ram_rd_data;

    always_comb begin
        if (r_s1.read) begin
            upd = '0;
        end else if (cur < rch_pkg::FRAME_SIZE) begin
            upd = cur + rch_pkg::t_count'(1);
        end else begin
            upd = cur;
        end
    end

    assign item_wr = r_s1.valid && r_s1.hit;
    assign wr_en   = i_req.clear || item_wr;
    assign wr_addr = i_req.clear ? i_clr_addr : r_s1_addr;
    assign wr_data = i_req.clear ? '0 : upd;

    rch_ram #(
        .WIDTH (rch_pkg::COUNT_W),
        .DEPTH (BIN_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (i_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1       <= '0;
            r_wb_valid <= 1'b0;
        end else begin
            r_s1       <= i_req;
            r_wb_valid <= item_wr && !i_req.clear;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= i_addr;
        r_wb_addr <= r_s1_addr;
        r_wb_data <= upd;
    end

    assign o_count = r_s1.hit ? cur : '0;

endmodule

// ===== hdl/rch_out_q.sv =====
// Two-entry result queue that decouples the tables from the receiver.
module rch_out_q (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rch_pkg::t_result i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output rch_pkg::t_result o_data,
    output logic [1:0]       o_level
);

    rch_pkg::t_result r_q [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_level;
    logic [1:0]       n_level;

    always_comb begin
        n_level = r_level;
        if (i_push && !i_pop) begin
            n_level = r_level + 2'd1;
        end else if (i_pop && !i_push) begin
            n_level = r_level - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_level != 2'd0);
    assign o_data  = r_q[r_rd_ptr];
    assign o_level = r_level;

endmodule

// ===== hdl/rch_checker.sv =====
// Port-level checks for the RGB channel histogram, bound to the top level.
module rch_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input logic            i_mode,
    input rch_pkg::t_value i_blue,
    input rch_pkg::t_value i_green,
    input rch_pkg::t_value i_red,
    input rch_pkg::t_value i_bin_index,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input rch_pkg::t_value o_bin_number,
    input rch_pkg::t_count o_blue_count,
    input rch_pkg::t_count o_green_count,
    input rch_pkg::t_count o_red_count
);

    // Reset empties the queue and starts the table sweep.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("ready or result shown straight after reset");

    // An accepted read item always produces a result after the modify stage.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_mode == rch_pkg::MODE_READ) |-> ##2 o_out_valid)
        else $error("read item produced no result");

    // Counts never pass the frame size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_blue_count <= rch_pkg::FRAME_SIZE)
                     && (o_green_count <= rch_pkg::FRAME_SIZE)
                     && (o_red_count <= rch_pkg::FRAME_SIZE))
        else $error("count above frame size");

    // A stalled result holds its bin number and blue count.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_bin_number)
                                     && $stable(o_blue_count))
        else $error("stalled result changed");

endmodule

bind rgb_channel_histogram_core rch_checker u_rch_checker (.*);

// ===== bench/rgb_channel_histogram_core_test.sv =====
// Testbench for the RGB channel histogram core: random and directed pixels and bin reads, scored against a bin tally.
`timescale 1ns / 1ps

module rgb_channel_histogram_core_test;

    localparam int BINS       = 256;
    localparam int CHANNELS   = 3;
    localparam int MAX_GAP    = 8;
    localparam int LIMIT      = 2000000;
    localparam int TAIL       = 8;

    // Running copy of the three bin tables plus the reads still owed a result.
    class bin_tally;
        rch_pkg::t_count  counts [rch_pkg::PORT_CHANNELS][BINS];
        rch_pkg::t_result awaited[$];
        int errors;
        int pixels;
        int reads;
        int checked;
        int full_counts;

        function new();
            for (int ch = 0; ch < rch_pkg::PORT_CHANNELS; ch++)
                for (int b = 0; b < BINS; b++)
                    counts[ch][b] = '0;
            errors = 0;
            pixels = 0;
            reads = 0;
            checked = 0;
            full_counts = 0;
        endfunction

        function void note_item(logic mode, rch_pkg::t_value blue, rch_pkg::t_value green,
                                rch_pkg::t_value red, rch_pkg::t_value bin_index);
            rch_pkg::t_value  pixel [rch_pkg::PORT_CHANNELS];
            rch_pkg::t_result res;
            pixel[0] = blue;
            pixel[1] = green;
            pixel[2] = red;
            if (mode == rch_pkg::MODE_ACCUMULATE) begin
                pixels++;
                // Count only kept channels and existing bins; hold at the frame size.
                for (int ch = 0; ch < rch_pkg::PORT_CHANNELS; ch++)
                    if (ch < CHANNELS && pixel[ch] < BINS &&
                        counts[ch][pixel[ch]] < rch_pkg::FRAME_SIZE)
                        counts[ch][pixel[ch]] = counts[ch][pixel[ch]] + 1'b1;
            end else begin
                reads++;
                res.bin_number = bin_index;
                for (int ch = 0; ch < rch_pkg::PORT_CHANNELS; ch++) begin
                    if (ch < CHANNELS && bin_index < BINS) begin
                        res.counts[ch] = counts[ch][bin_index];
                        counts[ch][bin_index] = '0;
                    end else begin
                        res.counts[ch] = '0;
                    end
                end
                awaited = {awaited, res};
            end
        endfunction

        function void check_result(rch_pkg::t_value bin_number, rch_pkg::t_count blue_count,
                                   rch_pkg::t_count green_count, rch_pkg::t_count red_count);
            rch_pkg::t_result want;
            rch_pkg::t_count  got [rch_pkg::PORT_CHANNELS];
            string            chan_name [rch_pkg::PORT_CHANNELS];
            chan_name = '{"blue", "green", "red"};
            checked++;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result for bin %0d arrived with no read awaiting it",
                         $time, bin_number);
                return;
            end
            want = awaited.pop_front();
            got[0] = blue_count;
            got[1] = green_count;
            got[2] = red_count;
            if (want.bin_number !== bin_number) begin
                errors++;
                $display("%0t: bin number expected %0d, got %0d",
                         $time, want.bin_number, bin_number);
            end
            for (int ch = 0; ch < rch_pkg::PORT_CHANNELS; ch++) begin
                if (want.counts[ch] !== got[ch]) begin
                    errors++;
                    $display("%0t: bin %0d %s count expected %0d, got %0d",
                             $time, want.bin_number, chan_name[ch], want.counts[ch], got[ch]);
                end
                if (want.counts[ch] == rch_pkg::FRAME_SIZE)
                    full_counts++;
            end
        endfunction
    endclass

    logic            i_clk         = 1'b0;
    logic            i_rst_n       = 1'b0;
    logic            i_in_valid    = 1'b0;
    logic            i_mode        = rch_pkg::MODE_ACCUMULATE;
    rch_pkg::t_value i_blue        = '0;
    rch_pkg::t_value i_green       = '0;
    rch_pkg::t_value i_red         = '0;
    rch_pkg::t_value i_bin_index   = '0;
    logic            i_out_ready   = 1'b0;
    logic            o_in_ready;
    logic            o_out_valid;
    rch_pkg::t_value o_bin_number;
    rch_pkg::t_count o_blue_count;
    rch_pkg::t_count o_green_count;
    rch_pkg::t_count o_red_count;

    bin_tally tally;
    int       in_idle_pct  = 0;
    int       out_idle_pct = 0;
    int       cycle_count  = 0;

    rgb_channel_histogram_core #(
        .BIN_COUNT     (BINS),
        .CHANNEL_COUNT (CHANNELS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_blue        (i_blue),
        .i_green       (i_green),
        .i_red         (i_red),
        .i_bin_index   (i_bin_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_bin_number  (o_bin_number),
        .o_blue_count  (o_blue_count),
        .o_green_count (o_green_count),
        .o_red_count   (o_red_count)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Take results on handshake and stall the output at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tally.check_result(o_bin_number, o_blue_count, o_green_count, o_red_count);
        i_out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Offer one item after an optional idle gap; return at the edge that accepts it.
    task automatic push_item(logic mode, rch_pkg::t_value blue, rch_pkg::t_value green,
                             rch_pkg::t_value red, rch_pkg::t_value bin_index);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < in_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= mode;
        i_blue      <= blue;
        i_green     <= green;
        i_red       <= red;
        i_bin_index <= bin_index;
        do @(posedge i_clk); while (!o_in_ready);
        tally.note_item(mode, blue, green, red, bin_index);
    endtask

    // Half the values come from a few hot bins so counts build up and reads find them.
    function automatic rch_pkg::t_value pick_value();
        rch_pkg::t_value hot [6];
        hot = '{8'h00, 8'h01, 8'h5A, 8'h80, 8'hFE, 8'hFF};
        if ($urandom_range(99) < 50)
            return hot[$urandom_range(5)];
        return rch_pkg::t_value'($urandom_range(255));
    endfunction

    task automatic push_random_item();
        logic mode;
        mode = ($urandom_range(99) < 30) ? rch_pkg::MODE_READ : rch_pkg::MODE_ACCUMULATE;
        push_item(mode, pick_value(), pick_value(), pick_value(), pick_value());
    endtask

    // Drop input valid and wait until every read has been answered.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tally.awaited.size() != 0);
    endtask

    initial begin
        tally = new();
        in_idle_pct  = 18;
        out_idle_pct = 73;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty bins after reset, with the unused pixel fields at both extremes.
        push_item(rch_pkg::MODE_READ, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        push_item(rch_pkg::MODE_READ, 8'h00, 8'h00, 8'h00, 8'hFF);
        // Lowest and highest bins, unused bin index set.
        push_item(rch_pkg::MODE_ACCUMULATE, 8'h00, 8'h00, 8'h00, 8'hFF);
        push_item(rch_pkg::MODE_ACCUMULATE, 8'hFF, 8'hFF, 8'hFF, 8'h00);
        push_item(rch_pkg::MODE_ACCUMULATE, 8'h00, 8'hFF, 8'h80, 8'hFF);
        push_item(rch_pkg::MODE_ACCUMULATE, 8'h00, 8'hFF, 8'h80, 8'h55);
        push_item(rch_pkg::MODE_READ, 8'h12, 8'h34, 8'h56, 8'h00);
        push_item(rch_pkg::MODE_READ, 8'h00, 8'h00, 8'h00, 8'hFF);
        push_item(rch_pkg::MODE_READ, 8'hFF, 8'hFF, 8'hFF, 8'h80);
        push_item(rch_pkg::MODE_READ, 8'hFF, 8'hFF, 8'hFF, 8'h80);
        // Read straight after a pixel to the same bin.
        push_item(rch_pkg::MODE_ACCUMULATE, 8'hAA, 8'h55, 8'hAA, 8'h00);
        push_item(rch_pkg::MODE_READ, 8'h00, 8'h00, 8'h00, 8'hAA);
        // Back-to-back pixels on one bin, then a pixel right after its clear.
        push_item(rch_pkg::MODE_ACCUMULATE, 8'h55, 8'hAA, 8'h55, 8'h00);
        push_item(rch_pkg::MODE_ACCUMULATE, 8'h55, 8'hAA, 8'h55, 8'hFF);
        push_item(rch_pkg::MODE_READ, 8'hAA, 8'hAA, 8'hAA, 8'h55);
        push_item(rch_pkg::MODE_ACCUMULATE, 8'h55, 8'h55, 8'h55, 8'h00);
        push_item(rch_pkg::MODE_READ, 8'h55, 8'h55, 8'h55, 8'h55);
        push_item(rch_pkg::MODE_READ, 8'h55, 8'h55, 8'h55, 8'hAA);

        for (int n = 0; n < 100; n++)
            push_random_item();
        wait_for_results();

        in_idle_pct  = 73;
        out_idle_pct = 18;
        for (int n = 0; n < 100; n++)
            push_random_item();
        wait_for_results();

        in_idle_pct  = 0;
        out_idle_pct = 0;
        for (int n = 0; n < 100; n++)
            push_random_item();
        // Read every bin in turn, as at the end of a frame.
        for (int b = 0; b < BINS; b++)
            push_item(rch_pkg::MODE_READ, pick_value(), pick_value(), pick_value(),
                      rch_pkg::t_value'(b));
        wait_for_results();
        repeat (TAIL) @(posedge i_clk);

        $display("Covered %0d pixels and %0d bin reads, %0d results checked, %0d full counts.",
                 tally.pixels, tally.reads, tally.checked, tally.full_counts);
        $display("Idle mixes: slow receiver, slow sender, none; ended with a sweep of all bins.");
        if (tally.errors == 0 && tally.awaited.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/rch_pkg.sv
hdl/rch_ram.sv
hdl/rch_chan.sv
hdl/rch_out_q.sv
hdl/rgb_channel_histogram_core.sv
hdl/rch_checker.sv
bench/rgb_channel_histogram_core_test.sv
